[design/isotp_pkg.sv]
`default_nettype none

package isotp_pkg;

   // PCI type codes (high nibble of frame byte 0)
   localparam logic [3:0] PCI_SINGLE = 4'd0;
   localparam logic [3:0] PCI_FIRST  = 4'd1;
   localparam logic [3:0] PCI_CONSEC = 4'd2;
   localparam logic [3:0] PCI_FLOW   = 4'd3;

   // flow status codes of received flow control
   localparam logic [3:0] FS_CONTINUE = 4'd0;
   localparam logic [3:0] FS_LAST     = 4'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_RX_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_FC_STATUS   = 2'd1;
   localparam logic [1:0] CSR_FC_STMIN    = 2'd2;

   localparam logic [11:0] CAPACITY_RESET = 12'd4095;
   localparam logic [12:0] MAX_MESSAGE_LENGTH = 13'd4095;

   // block plan and flow control points
   localparam logic [11:0] BLOCK_ONE_LIMIT = 12'd1785;
   localparam logic [11:0] BLOCK_TWO_LIMIT = 12'd3570;
   localparam logic [11:0] FC_POINT_ONE    = 12'd1791;
   localparam logic [11:0] FC_POINT_TWO    = 12'd3576;
   localparam logic [7:0]  FULL_BLOCK      = 8'd255;
   localparam logic [11:0] FRAME_DATA      = 12'd7;
   localparam logic [11:0] FIRST_DATA      = 12'd6;
   localparam logic [3:0]  SINGLE_MAX      = 4'd7;

   // ceil(len / 7) as (len + 6) * 2341 >> 14, exact for len + 6 up to 1791
   localparam logic [11:0] RECIP_SEVEN = 12'd2341;
   localparam int          RECIP_SHIFT = 14;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int JOB_BYTES   = 7;

   typedef enum logic [1:0] {
      RX_IDLE     = 2'd0,
      RX_PROGRESS = 2'd1,
      RX_FULL     = 2'd2
   } rx_state_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_FC     = 2'd1,
      KIND_STATUS = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      CODE_OK       = 3'd0,
      CODE_WRONG_SN = 3'd1,
      CODE_LENGTH   = 3'd2,
      CODE_OVERFLOW = 3'd3,
      CODE_IGNORED  = 3'd4
   } result_code_type;

   // one classified frame, as handed from front to back
   typedef struct packed {
      logic [2:0]                  num_writes;
      logic [11:0]                 base_offset;
      logic [JOB_BYTES-1:0][7:0]   data;
      logic                        fc_en;
      logic [3:0]                  fc_status;
      logic [7:0]                  fc_block_size;
      logic [7:0]                  fc_stmin;
      rx_state_type                rx_state;
      result_code_type             code;
      logic [11:0]                 length;
      logic [7:0]                  credit;
   } job_type;

   // frames needed for len bytes at seven per frame
   function automatic logic [7:0] frames_for(input logic [11:0] len);
      logic [11:0] padded;
      logic [23:0] prod;
      padded = len + 12'd6;
      prod = {12'b0, padded} * {12'b0, RECIP_SEVEN};
      return prod[RECIP_SHIFT+7:RECIP_SHIFT];
   endfunction

endpackage

`default_nettype wire

[design/isotp_front.sv]
`default_nettype none

module isotp_front
   import isotp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pci_byte,
   input  wire logic [7:0]  req_frame_byte_1,
   input  wire logic [7:0]  req_frame_byte_2,
   input  wire logic [7:0]  req_frame_byte_3,
   input  wire logic [7:0]  req_frame_byte_4,
   input  wire logic [7:0]  req_frame_byte_5,
   input  wire logic [7:0]  req_frame_byte_6,
   input  wire logic [7:0]  req_frame_byte_7,
   input  wire logic [11:0] cfg_capacity,
   input  wire logic [3:0]  cfg_fc_status,
   input  wire logic [7:0]  cfg_fc_stmin,
   input  wire logic        queue_full,
   output logic             push,
   output job_type          push_job
);

   // reassembly state
   rx_state_type rx_status_ff, rx_status_in;
   logic [11:0]  rx_length_ff, rx_length_in;
   logic [11:0]  rx_offset_ff, rx_offset_in;
   logic [3:0]   exp_seq_ff, exp_seq_in;
   logic [7:0]   cur_frames_ff, cur_frames_in;
   logic [1:0]   block_count_ff, block_count_in;
   logic [7:0]   last_frames_ff, last_frames_in;
   logic [7:0]   credit_ff, credit_in;

   // decode results
   logic [3:0]      pci_kind;
   logic [3:0]      pci_low;
   logic [11:0]     first_len;
   result_code_type code;
   logic            sf_ok, ff_ok, ff_ovf, cf_ok, credit_ld;
   logic [11:0]     avail;
   logic [2:0]      rem;
   logic [11:0]     off_sum;
   logic            fc_point_one, fc_point_two;
   logic [11:0]     plan_arg;
   logic [7:0]      plan_frames;
   logic            accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   assign pci_kind  = req_pci_byte[7:4];
   assign pci_low   = req_pci_byte[3:0];
   assign first_len = {pci_low, req_frame_byte_1};

   // classify the frame
   always_comb begin
      code      = CODE_OK;
      sf_ok     = 1'b0;
      ff_ok     = 1'b0;
      ff_ovf    = 1'b0;
      cf_ok     = 1'b0;
      credit_ld = 1'b0;
      case (pci_kind)
         PCI_SINGLE: begin
            if (rx_status_ff == RX_PROGRESS) code = CODE_IGNORED;
            else if (pci_low == 4'd0 || pci_low > SINGLE_MAX) code = CODE_LENGTH;
            else sf_ok = 1'b1;
         end
         PCI_FIRST: begin
            if (rx_status_ff == RX_PROGRESS) code = CODE_IGNORED;
            else if (first_len <= FRAME_DATA) code = CODE_LENGTH;
            else if (first_len > cfg_capacity ||
                     {1'b0, first_len} > MAX_MESSAGE_LENGTH) begin
               code   = CODE_OVERFLOW;
               ff_ovf = 1'b1;
            end else ff_ok = 1'b1;
         end
         PCI_CONSEC: begin
            if (rx_status_ff != RX_PROGRESS) code = CODE_IGNORED;
            else if (pci_low != exp_seq_ff) code = CODE_WRONG_SN;
            else cf_ok = 1'b1;
         end
         PCI_FLOW: begin
            if (pci_low > FS_LAST) code = CODE_IGNORED;
            else if (pci_low == FS_CONTINUE && req_frame_byte_1 != 8'd0) credit_ld = 1'b1;
         end
         default: code = CODE_IGNORED;
      endcase
   end

   // consecutive frame: bytes still owed, clamped to one frame
   always_comb begin
      avail = (rx_length_ff > rx_offset_ff) ? rx_length_ff - rx_offset_ff : 12'd0;
      rem   = (avail > FRAME_DATA) ? 3'd7 : avail[2:0];
      off_sum = rx_offset_ff + {9'b0, rem};
      fc_point_one = (off_sum == FC_POINT_ONE) &&
                     (block_count_ff == 2'd2 || block_count_ff == 2'd3);
      fc_point_two = (off_sum == FC_POINT_TWO) && (block_count_ff == 2'd3);
   end

   // first frame: block plan, one shared frame count unit
   always_comb begin
      if (first_len <= BLOCK_ONE_LIMIT) plan_arg = first_len;
      else if (first_len <= BLOCK_TWO_LIMIT) plan_arg = first_len - BLOCK_ONE_LIMIT;
      else plan_arg = first_len - BLOCK_TWO_LIMIT;
      plan_frames = frames_for(plan_arg);
   end

   // next state
   always_comb begin
      rx_status_in   = rx_status_ff;
      rx_length_in   = rx_length_ff;
      rx_offset_in   = rx_offset_ff;
      exp_seq_in     = exp_seq_ff;
      cur_frames_in  = cur_frames_ff;
      block_count_in = block_count_ff;
      last_frames_in = last_frames_ff;
      credit_in      = credit_ff;
      if (sf_ok) rx_length_in = {8'b0, pci_low};
      if (ff_ovf) rx_status_in = RX_IDLE;
      if (ff_ok) begin
         if (first_len <= BLOCK_ONE_LIMIT) begin
            cur_frames_in  = plan_frames;
            block_count_in = 2'd1;
            last_frames_in = 8'd0;
         end else if (first_len <= BLOCK_TWO_LIMIT) begin
            cur_frames_in  = FULL_BLOCK;
            block_count_in = 2'd2;
            last_frames_in = plan_frames;
         end else begin
            cur_frames_in  = FULL_BLOCK;
            block_count_in = 2'd3;
            last_frames_in = plan_frames;
         end
         rx_length_in = first_len;
         rx_offset_in = FIRST_DATA;
         exp_seq_in   = 4'd1;
         rx_status_in = RX_PROGRESS;
      end
      if (cf_ok) begin
         rx_offset_in = off_sum;
         exp_seq_in   = exp_seq_ff + 4'd1;
         if (off_sum >= rx_length_ff) rx_status_in = RX_FULL;
         if (fc_point_one && block_count_ff == 2'd2) cur_frames_in = last_frames_ff;
         if (fc_point_one && block_count_ff == 2'd3) cur_frames_in = FULL_BLOCK;
         if (fc_point_two) cur_frames_in = last_frames_ff;
      end
      if (credit_ld) credit_in = req_frame_byte_1;
   end

   // job for the back end
   always_comb begin
      push_job = '0;
      push_job.data[0] = req_frame_byte_1;
      push_job.data[1] = req_frame_byte_2;
      push_job.data[2] = req_frame_byte_3;
      push_job.data[3] = req_frame_byte_4;
      push_job.data[4] = req_frame_byte_5;
      push_job.data[5] = req_frame_byte_6;
      push_job.data[6] = req_frame_byte_7;
      if (sf_ok) push_job.num_writes = pci_low[2:0];
      if (ff_ok) begin
         push_job.num_writes = 3'd6;
         push_job.data[0] = req_frame_byte_2;
         push_job.data[1] = req_frame_byte_3;
         push_job.data[2] = req_frame_byte_4;
         push_job.data[3] = req_frame_byte_5;
         push_job.data[4] = req_frame_byte_6;
         push_job.data[5] = req_frame_byte_7;
         push_job.data[6] = 8'd0;
         push_job.fc_en = 1'b1;
      end
      if (cf_ok) begin
         push_job.num_writes  = rem;
         push_job.base_offset = rx_offset_ff;
         push_job.fc_en       = fc_point_one || fc_point_two;
      end
      push_job.fc_status     = cfg_fc_status;
      push_job.fc_block_size = cur_frames_in;
      push_job.fc_stmin      = cfg_fc_stmin;
      push_job.rx_state      = rx_status_in;
      push_job.code          = code;
      push_job.length        = rx_length_in;
      push_job.credit        = credit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_status_ff   <= RX_IDLE;
         rx_length_ff   <= 12'd0;
         rx_offset_ff   <= 12'd0;
         exp_seq_ff     <= 4'd0;
         cur_frames_ff  <= 8'd0;
         block_count_ff <= 2'd0;
         last_frames_ff <= 8'd0;
         credit_ff      <= 8'd0;
      end else if (accept) begin
         rx_status_ff   <= rx_status_in;
         rx_length_ff   <= rx_length_in;
         rx_offset_ff   <= rx_offset_in;
         exp_seq_ff     <= exp_seq_in;
         cur_frames_ff  <= cur_frames_in;
         block_count_ff <= block_count_in;
         last_frames_ff <= last_frames_in;
         credit_ff      <= credit_in;
      end
   end

endmodule

`default_nettype wire

[design/isotp_queue.sv]
`default_nettype none

module isotp_queue
   import isotp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output job_type      pop_job
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
   end

   // never written when full, never read when empty; a lone push raises the fill count
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid) else $error("job queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("job queue fill count lost a push");

endmodule

`default_nettype wire

[design/isotp_back.sv]
`default_nettype none

module isotp_back
   import isotp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [1:0]   rsp_result_kind,
   output logic [11:0]  rsp_write_offset,
   output logic [7:0]   rsp_payload_byte,
   output logic [3:0]   rsp_fc_flow_status,
   output logic [7:0]   rsp_fc_block_size,
   output logic [7:0]   rsp_fc_stmin,
   output logic [1:0]   rsp_receive_state,
   output logic [2:0]   rsp_result_code,
   output logic [11:0]  rsp_message_length,
   output logic [7:0]   rsp_tx_block_credit,
   output logic         rsp_last
);

   // job in progress and beat index
   job_type     job_ff;
   logic        busy_ff, busy_in;
   logic [2:0]  idx_ff, idx_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   result_kind_type kind_ff, kind_in;
   logic [11:0] offset_ff, offset_in;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  fs_ff, fs_in;
   logic [7:0]  bs_ff, bs_in;
   logic [7:0]  stmin_ff, stmin_in;
   logic        last_ff, last_in;

   logic [3:0]  beat_count;
   logic [2:0]  last_idx;
   logic        load;
   logic        final_beat;

   // beats in this job: writes then flow control, or one status beat
   always_comb begin
      beat_count = {1'b0, job_ff.num_writes} + {3'b0, job_ff.fc_en};
      last_idx   = (beat_count == 4'd0) ? 3'd0 : 3'(beat_count - 4'd1);
   end

   assign load       = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign final_beat = (idx_ff == last_idx);
   assign job_pop    = job_valid && (!busy_ff || (load && final_beat));

   // next control state
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (load) begin
         if (final_beat) busy_in = 1'b0;
         idx_in = idx_ff + 3'd1;
      end
      if (load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // beat contents
   always_comb begin
      kind_in   = KIND_STATUS;
      offset_in = 12'd0;
      byte_in   = 8'd0;
      fs_in     = 4'd0;
      bs_in     = 8'd0;
      stmin_in  = 8'd0;
      if (idx_ff < job_ff.num_writes) begin
         kind_in   = KIND_WRITE;
         offset_in = job_ff.base_offset + {9'b0, idx_ff};
         byte_in   = job_ff.data[idx_ff];
      end else if (job_ff.fc_en) begin
         kind_in  = KIND_FC;
         fs_in    = job_ff.fc_status;
         bs_in    = job_ff.fc_block_size;
         stmin_in = job_ff.fc_stmin;
      end
      last_in = final_beat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job;
      if (load) begin
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         byte_ff   <= byte_in;
         fs_ff     <= fs_in;
         bs_ff     <= bs_in;
         stmin_ff  <= stmin_in;
         last_ff   <= last_in;
         rsp_receive_state   <= job_ff.rx_state;
         rsp_result_code     <= job_ff.code;
         rsp_message_length  <= job_ff.length;
         rsp_tx_block_credit <= job_ff.credit;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_write_offset   = offset_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_fc_flow_status = fs_ff;
   assign rsp_fc_block_size  = bs_ff;
   assign rsp_fc_stmin       = stmin_ff;
   assign rsp_last           = last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= last_idx) else $error("beat index past end of job");
   a_beats_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !last_ff |=> rsp_valid_ff)
      else $error("gap inside one frame's results");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_STATUS |-> last_ff)
      else $error("status beat not marked last");

endmodule

`default_nettype wire

[design/isotp_receive_reassembler_core.sv]
`default_nettype none

// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | one CAN frame: PCI byte, bytes 1..7
// rsp     | out       | rsp_valid/rsp_stall  | one result beat, rsp_last on a frame's final beat
// csr     | in        | csr_wr_en            | csr_index selects register, csr_wdata value
//
// A frame is taken while the two-entry job queue has room; the back end sends one result
// beat per clock while rsp_stall is low, 1 to 8 beats per frame. With an idle back end a
// frame passes the job queue, the job register and the output register before its first
// result beat is valid.
// Reset is synchronous: it clears reassembly state, loads register defaults and empties
// the queue and output register. rsp_stall holds the output register; the queue then
// fills and raises req_stall.

module isotp_receive_reassembler_core
   import isotp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pci_byte,
   input  wire logic [7:0]  req_frame_byte_1,
   input  wire logic [7:0]  req_frame_byte_2,
   input  wire logic [7:0]  req_frame_byte_3,
   input  wire logic [7:0]  req_frame_byte_4,
   input  wire logic [7:0]  req_frame_byte_5,
   input  wire logic [7:0]  req_frame_byte_6,
   input  wire logic [7:0]  req_frame_byte_7,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [11:0]      rsp_write_offset,
   output logic [7:0]       rsp_payload_byte,
   output logic [3:0]       rsp_fc_flow_status,
   output logic [7:0]       rsp_fc_block_size,
   output logic [7:0]       rsp_fc_stmin,
   output logic [1:0]       rsp_receive_state,
   output logic [2:0]       rsp_result_code,
   output logic [11:0]      rsp_message_length,
   output logic [7:0]       rsp_tx_block_credit,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);

   // configuration registers
   logic [11:0] capacity_ff;
   logic [3:0]  fc_status_ff;
   logic [7:0]  fc_stmin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         fc_status_ff <= 4'd0;
         fc_stmin_ff  <= 8'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RX_CAPACITY: capacity_ff  <= csr_wdata;
            CSR_FC_STATUS:   fc_status_ff <= csr_wdata[3:0];
            CSR_FC_STMIN:    fc_stmin_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic    q_push, q_full, q_pop, q_valid;
   job_type q_push_job, q_pop_job;

   isotp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pci_byte     (req_pci_byte),
      .req_frame_byte_1 (req_frame_byte_1),
      .req_frame_byte_2 (req_frame_byte_2),
      .req_frame_byte_3 (req_frame_byte_3),
      .req_frame_byte_4 (req_frame_byte_4),
      .req_frame_byte_5 (req_frame_byte_5),
      .req_frame_byte_6 (req_frame_byte_6),
      .req_frame_byte_7 (req_frame_byte_7),
      .cfg_capacity     (capacity_ff),
      .cfg_fc_status    (fc_status_ff),
      .cfg_fc_stmin     (fc_stmin_ff),
      .queue_full       (q_full),
      .push             (q_push),
      .push_job         (q_push_job)
   );

   isotp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_pop_job)
   );

   isotp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (q_valid),
      .job                 (q_pop_job),
      .job_pop             (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_write_offset    (rsp_write_offset),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_fc_flow_status  (rsp_fc_flow_status),
      .rsp_fc_block_size   (rsp_fc_block_size),
      .rsp_fc_stmin        (rsp_fc_stmin),
      .rsp_receive_state   (rsp_receive_state),
      .rsp_result_code     (rsp_result_code),
      .rsp_message_length  (rsp_message_length),
      .rsp_tx_block_credit (rsp_tx_block_credit),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire
